>>> sv/assert_macros.svh
// Assertion macros used by the top level of the chained hash table store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is never true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/cht_pkg.sv
// Types, widths and codes shared by the chained hash table store.
package cht_pkg;

    // Field widths of one word on each side.
    localparam int KEY_W    = 40;
    localparam int NAME_W   = 64;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 72;

    // Default table geometry.
    localparam int BUCKETS_DEF = 16;
    localparam int WAYS_DEF    = 8;

    // Key bits folded into the bucket remainder per cycle.
    localparam int HASH_DIG   = 8;
    localparam int HASH_STEPS = KEY_W / HASH_DIG;

    // Operation codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_SEARCH = 2'd2
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    // One chain entry as stored in the entry memory.
    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [KEY_W-1:0]  key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> sv/chained_hash_table_store.sv
// Chained hash table store: top level with sequencer, entry and fill memories.
//
//  channel | dir | fields (low bit first)                      | handshake
//  s_axis  | in  | func[1:0] key[41:2] name_value[105:42]      | tvalid/tready
//  m_axis  | out | status[1:0] found_name[65:2]                | tvalid/tready
//
// The bucket index takes five 8-bit digit folds plus a done step, then the
// fill count is read, the chain is scanned entry by entry, a delete shifts
// each later entry down one slot, and the result goes to the output register.
// The one entry read a cycle sets the scan.
// Reset clears the fill valid bits; entry memory is not cleared.
// A result waiting in the output register does not stop the next word, but
// the sequencer holds its last step until that register is free.
`include "assert_macros.svh"

module chained_hash_table_store #(
    parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
    parameter int WAYS    = cht_pkg::WAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // func[1:0], key[41:2], name_value[105:42], zero[111:106]
    input  logic [cht_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[1:0], found_name[65:2], zero[71:66]
    output logic [cht_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import cht_pkg::*;

    localparam int SLOTS = BUCKETS * WAYS;
    localparam int AW    = $clog2(SLOTS);
    localparam int BW    = $clog2(BUCKETS);
    localparam int CNT_W = $clog2(WAYS + 1);
    localparam logic [AW-1:0]    WAYS_A = AW'(WAYS);
    localparam logic [CNT_W-1:0] WAYS_C = CNT_W'(WAYS);
    localparam int PAD_W = M_TDATA_W - STATUS_W - NAME_W;

    typedef enum logic [5:0] {
        SM_IDLE  = 6'b000001,
        SM_HASH  = 6'b000010,
        SM_FILL  = 6'b000100,
        SM_SCAN  = 6'b001000,
        SM_SHIFT = 6'b010000,
        SM_DONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    func_t             func_reg, func_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [NAME_W-1:0] name_reg, name_next;
    logic [BW-1:0]     bucket_reg, bucket_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    status_t           res_status_reg, res_status_next;
    logic [NAME_W-1:0] res_name_reg, res_name_next;
    logic              out_vld_reg, out_vld_next;
    status_t           out_status_reg, out_status_next;
    logic [NAME_W-1:0] out_name_reg, out_name_next;
    logic [BUCKETS-1:0] fill_vld_reg, fill_vld_next;

    logic              in_fire;
    logic              hash_done;
    logic [BW-1:0]     hash_bucket;

    logic              ent_we;
    logic [AW-1:0]     ent_waddr, ent_raddr;
    entry_t            ent_wdata, ent_rdata;
    logic              fill_we;
    logic [BW-1:0]     fill_raddr;
    logic [CNT_W-1:0]  fill_wdata, fill_rdata, fill_cur;
    logic [CNT_W:0]    idx_p1, idx_p2, fill_x;
    logic              hit;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == SM_IDLE);

    // Bucket index unit.
    cht_hash #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_fire),
        .key    (s_axis_tdata[FUNC_W +: KEY_W]),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    // Entry memory: key and name of every chain slot.
    cht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // Fill count memory, one count per bucket; valid bits stand in for reset.
    cht_ram #(
        .WIDTH (CNT_W),
        .DEPTH (BUCKETS),
        .AW    (BW)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (bucket_reg),
        .wdata (fill_wdata),
        .raddr (fill_raddr),
        .rdata (fill_rdata)
    );

    assign fill_raddr = (state_reg == SM_HASH) ? hash_bucket : bucket_reg;
    assign fill_cur   = fill_vld_reg[bucket_reg] ? fill_rdata : '0;
    assign idx_p1     = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(1);
    assign idx_p2     = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(2);
    assign fill_x     = (CNT_W + 1)'(fill_reg);
    assign hit        = (ent_rdata.key == key_reg);

    // Sequencer: hash, read fill count, scan chain, shift on delete.
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        name_next       = name_reg;
        bucket_next     = bucket_reg;
        base_next       = base_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_name_next   = res_name_reg;
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_name_next   = out_name_reg;
        fill_vld_next   = fill_vld_reg;
        ent_we          = 1'b0;
        ent_waddr       = base_reg + AW'(idx_reg);
        ent_wdata       = ent_rdata;
        ent_raddr       = base_reg;
        fill_we         = 1'b0;
        fill_wdata      = fill_reg;

        // The output register empties when the consumer takes the word.
        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            SM_IDLE:
            begin
                if (in_fire)
                begin
                    func_next  = func_t'(s_axis_tdata[FUNC_W-1:0]);
                    key_next   = s_axis_tdata[FUNC_W +: KEY_W];
                    name_next  = s_axis_tdata[FUNC_W + KEY_W +: NAME_W];
                    state_next = SM_HASH;
                end
            end
            SM_HASH:
            begin
                if (hash_done)
                begin
                    bucket_next = hash_bucket;
                    base_next   = AW'(hash_bucket) * WAYS_A;
                    state_next  = SM_FILL;
                end
            end
            SM_FILL:
            begin
                fill_next       = fill_cur;
                idx_next        = '0;
                res_status_next = STAT_OK;
                res_name_next   = '0;
                state_next      = SM_DONE;
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (fill_cur >= WAYS_C)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            ent_we         = 1'b1;
                            ent_waddr      = base_reg + AW'(fill_cur);
                            ent_wdata.key  = key_reg;
                            ent_wdata.name = name_reg;
                            fill_we        = 1'b1;
                            fill_wdata     = fill_cur + CNT_W'(1);
                            fill_vld_next[bucket_reg] = 1'b1;
                        end
                    end
                    FUNC_DELETE, FUNC_SEARCH:
                    begin
                        if (fill_cur == '0)
                        begin
                            res_status_next = STAT_MISS;
                        end
                        else
                        begin
                            state_next = SM_SCAN;
                        end
                    end
                    default:
                    begin
                        res_status_next = STAT_OK;
                    end
                endcase
            end
            SM_SCAN:
            begin
                // Read data holds entry idx; fetch the next one ahead.
                if (idx_p1 < fill_x)
                begin
                    ent_raddr = base_reg + AW'(idx_p1);
                end
                else
                begin
                    ent_raddr = base_reg + AW'(idx_reg);
                end
                if (hit)
                begin
                    res_status_next = STAT_OK;
                    state_next      = SM_DONE;
                    if (func_reg == FUNC_SEARCH)
                    begin
                        res_name_next = ent_rdata.name;
                    end
                    else
                    begin
                        fill_we    = 1'b1;
                        fill_wdata = fill_reg - CNT_W'(1);
                        if (idx_p1 < fill_x)
                        begin
                            state_next = SM_SHIFT;
                        end
                    end
                end
                else if (idx_p1 < fill_x)
                begin
                    idx_next = idx_p1[CNT_W-1:0];
                end
                else
                begin
                    res_status_next = STAT_MISS;
                    state_next      = SM_DONE;
                end
            end
            SM_SHIFT:
            begin
                // Move entry idx+1 into slot idx while fetching entry idx+2.
                ent_we    = 1'b1;
                ent_waddr = base_reg + AW'(idx_reg);
                ent_wdata = ent_rdata;
                if (idx_p2 < fill_x)
                begin
                    ent_raddr = base_reg + AW'(idx_p2);
                    idx_next  = idx_p1[CNT_W-1:0];
                end
                else
                begin
                    ent_raddr  = base_reg + AW'(idx_p1);
                    state_next = SM_DONE;
                end
            end
            SM_DONE:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_name_next   = res_name_reg;
                    state_next      = SM_IDLE;
                end
            end
            default:
            begin
                state_next = SM_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SM_IDLE;
            out_vld_reg  <= 1'b0;
            fill_vld_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            out_vld_reg  <= out_vld_next;
            fill_vld_reg <= fill_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        name_reg       <= name_next;
        bucket_reg     <= bucket_next;
        base_reg       <= base_next;
        fill_reg       <= fill_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_name_reg   <= res_name_next;
        out_status_reg <= out_status_next;
        out_name_reg   <= out_name_next;
    end

    // Output word.
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_name_reg, out_status_reg};

    // Checks on the sequencer and memory traffic.
    `ASSERT_PROP(a_fill_bound, clk, rst_n, fill_we |-> (fill_wdata <= WAYS_C), "fill count above WAYS")
    `ASSERT_PROP(a_scan_index, clk, rst_n, (state_reg == SM_SCAN) |-> ((CNT_W + 1)'(idx_reg) < fill_x), "scan past chain end")
    `ASSERT_PROP(a_entry_write, clk, rst_n, ent_we |-> (state_reg == SM_FILL || state_reg == SM_SHIFT), "entry write outside insert or shift")
    `ASSERT_NEVER(a_miss_name, clk, rst_n, out_vld_reg && (out_status_reg != STAT_OK) && (out_name_reg != '0), "name returned with failing status")

endmodule

>>> sv/cht_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/cht_hash.sv
// Bucket index unit: key modulo BUCKETS, eight key bits per cycle, MSB first.
module cht_hash #(
    parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
    parameter int BW      = $clog2(BUCKETS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [cht_pkg::KEY_W-1:0] key,
    output logic                   done,
    output logic [BW-1:0]          bucket
);
    import cht_pkg::*;

    localparam int HCNT_W = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;
    localparam int DIG_VALS = 2 ** HASH_DIG;
    localparam logic [BW:0] BUCKETS_X = (BW + 1)'(BUCKETS);

    logic [KEY_W-1:0]  hkey_reg, hkey_next;
    logic [BW-1:0]     rem_reg, rem_next;
    logic [HCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [BW-1:0]     fold;

    // Constant remainder tables: each remainder shifted up by one digit, and
    // each digit value, both reduced modulo BUCKETS.
    logic [BUCKETS*BW-1:0]  shift_tab;
    logic [DIG_VALS*BW-1:0] digit_tab;

    genvar g;

    for (g = 0; g < BUCKETS; g++)
    begin : g_shift_tab
        assign shift_tab[g*BW +: BW] = BW'((g * DIG_VALS) % BUCKETS);
    end

    for (g = 0; g < DIG_VALS; g++)
    begin : g_digit_tab
        assign digit_tab[g*BW +: BW] = BW'(g % BUCKETS);
    end

    // Fold the top digit of the key into the remainder: both table terms are
    // below BUCKETS, so one compare and subtract brings the sum back in range.
    always_comb
    begin
        logic [BW:0] t;
        t = {1'b0, shift_tab[int'(rem_reg) * BW +: BW]}
          + {1'b0, digit_tab[int'(hkey_reg[KEY_W-1 -: HASH_DIG]) * BW +: BW]};
        if (t >= BUCKETS_X)
        begin
            t = t - BUCKETS_X;
        end
        fold = t[BW-1:0];
    end

    // Step control.
    always_comb
    begin
        hkey_next = hkey_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            hkey_next = key;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hkey_next = hkey_reg << HASH_DIG;
            rem_next  = fold;
            cnt_next  = cnt_reg + HCNT_W'(1);
            if (cnt_reg == HCNT_W'(HASH_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hkey_reg <= hkey_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule
